[sv/efp_pkg.sv]
// Shared constants and controller/datapath interface types for the Euler path block.
package efp_pkg;

  localparam int NODE_W          = 3;
  localparam int NODE_COUNT_DEF  = 7;
  localparam int MAX_TILES_DEF   = 32;

  localparam logic [1:0] ST_PATH   = 2'd0;
  localparam logic [1:0] ST_NOCONN = 2'd1;
  localparam logic [1:0] ST_ODD    = 2'd2;
  localparam logic [1:0] ST_OVF    = 2'd3;

  typedef struct packed {
    logic       load;
    logic       conn_init;
    logic       bfs_step;
    logic       bridge_init;
    logic       scan_start;
    logic       t_adv;
    logic       set_fb;
    logic       take;
    logic       take_fb;
    logic       set_start;
    logic       emit_fail;
    logic [1:0] fail_code;
    logic       emit_final;
    logic       clear;
  } cmd_t;

  typedef struct packed {
    logic grew;
    logic conn_ok;
    logic no_nodes;
    logic odd_many;
    logic overflow;
    logic t_end;
    logic used_t;
    logic incident;
    logic self_loop;
    logic far_reached;
    logic fb_valid;
  } sts_t;

endpackage

[sv/efp_ctrl.sv]
// Sequencer for tile loading, connectivity check and the Fleury walk.
module efp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_last_tile,
  input  efp_pkg::sts_t sts,
  output efp_pkg::cmd_t cmd,
  output logic          busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_CONN  = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_BR    = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_last_tile) state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts.overflow) begin
          cmd.emit_fail = 1'b1;
          cmd.fail_code = efp_pkg::ST_OVF;
          cmd.clear     = 1'b1;
          state_nxt     = S_IDLE;
        end else if (sts.no_nodes) begin
          cmd.emit_fail = 1'b1;
          cmd.fail_code = efp_pkg::ST_NOCONN;
          cmd.clear     = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.conn_init = 1'b1;
          state_nxt     = S_CONN;
        end
      end
      S_CONN: begin
        cmd.bfs_step = 1'b1;
        if (!sts.grew) begin
          priority if (!sts.conn_ok) begin
            cmd.emit_fail = 1'b1;
            cmd.fail_code = efp_pkg::ST_NOCONN;
            cmd.clear     = 1'b1;
            state_nxt     = S_IDLE;
          end else if (sts.odd_many) begin
            cmd.emit_fail = 1'b1;
            cmd.fail_code = efp_pkg::ST_ODD;
            cmd.clear     = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cmd.set_start  = 1'b1;
            cmd.scan_start = 1'b1;
            state_nxt      = S_RD;
          end
        end
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        priority if (sts.t_end) begin
          if (sts.fb_valid) begin
            cmd.take       = 1'b1;
            cmd.take_fb    = 1'b1;
            cmd.scan_start = 1'b1;
            state_nxt      = S_RD;
          end else begin
            cmd.emit_final = 1'b1;
            cmd.clear      = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else if (sts.used_t || !sts.incident) begin
          cmd.t_adv = 1'b1;
          state_nxt = S_RD;
        end else begin
          if (sts.self_loop) begin
            cmd.take       = 1'b1;
            cmd.scan_start = 1'b1;
            state_nxt      = S_RD;
          end else begin
            cmd.set_fb      = !sts.fb_valid;
            cmd.bridge_init = 1'b1;
            state_nxt       = S_BR;
          end
        end
      end
      S_BR: begin
        cmd.bfs_step = 1'b1;
        if (!sts.grew) begin
          if (sts.far_reached) begin
            cmd.take       = 1'b1;
            cmd.scan_start = 1'b1;
          end else begin
            cmd.t_adv = 1'b1;
          end
          state_nxt = S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

[sv/efp_dp.sv]
// Graph stores, reachability step, tile scan and result registers.
module efp_dp #(
  parameter int NODE_COUNT = efp_pkg::NODE_COUNT_DEF,
  parameter int MAX_TILES  = efp_pkg::MAX_TILES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [efp_pkg::NODE_W-1:0] in_tile_end_a,
  input  logic [efp_pkg::NODE_W-1:0] in_tile_end_b,
  input  efp_pkg::cmd_t             cmd,
  output efp_pkg::sts_t             sts,
  output logic                      out_valid,
  output logic [efp_pkg::NODE_W-1:0] out_path_node,
  output logic [1:0]                out_status,
  output logic                      out_last_result
);

  localparam int NW = efp_pkg::NODE_W;
  localparam int CW = $clog2(MAX_TILES + 1);
  localparam int DW = $clog2(2 * MAX_TILES + 1);
  localparam int IW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;

  logic [CW-1:0]   cnt_r [NODE_COUNT][NODE_COUNT];
  logic [DW-1:0]   deg_r [NODE_COUNT];
  logic [MAX_TILES-1:0] used_r;
  logic [CW-1:0]   total_r, t_r;
  logic            overflow_r, ex_r, fb_valid_r;
  logic [IW-1:0]   fb_t_r;
  logic [NW-1:0]   fb_a_r, fb_b_r, cur_r;
  logic [NODE_COUNT-1:0] reach_r;
  logic [2*NW-1:0] mem [MAX_TILES];
  logic [2*NW-1:0] rd_r;

  logic [NW-1:0]   rd_a, rd_b, ta, tb, start_node, low_odd, low_nz;
  logic [NODE_COUNT-1:0] reach_step, odd_bits, nz_bits;
  logic [IW-1:0]   take_idx;
  logic            tile_ok, store_ok, far;

  assign rd_a = rd_r[2*NW-1:NW];
  assign rd_b = rd_r[NW-1:0];
  assign ta   = cmd.take_fb ? fb_a_r : rd_a;
  assign tb   = cmd.take_fb ? fb_b_r : rd_b;
  assign take_idx = cmd.take_fb ? fb_t_r : t_r[IW-1:0];
  assign tile_ok  = ({1'b0, in_tile_end_a} < (NW+1)'(NODE_COUNT)) &&
                    ({1'b0, in_tile_end_b} < (NW+1)'(NODE_COUNT));
  assign store_ok = cmd.load && tile_ok && (total_r < CW'(MAX_TILES));

  // One reachability step plus degree parity and lowest odd/nonzero nodes; the edge under test loses one copy.
  always_comb begin
    logic adj;
    reach_step = reach_r;
    far        = 1'b0;
    odd_bits   = '0;
    nz_bits    = '0;
    low_odd    = '0;
    low_nz     = '0;
    for (int u = 0; u < NODE_COUNT; u++) begin
      for (int v = 0; v < NODE_COUNT; v++) begin
        adj = (cnt_r[u][v] != '0) &&
              !(ex_r && (cnt_r[u][v] == CW'(1)) &&
                (((rd_a == NW'(u)) && (rd_b == NW'(v))) ||
                 ((rd_a == NW'(v)) && (rd_b == NW'(u)))));
        if (reach_r[u] && adj) reach_step[v] = 1'b1;
      end
      if (rd_b == NW'(u)) far = reach_r[u];
      odd_bits[u] = deg_r[u][0];
      nz_bits[u]  = (deg_r[u] != '0);
    end
    for (int i = NODE_COUNT - 1; i >= 0; i--) begin
      if (odd_bits[i]) low_odd = NW'(i);
      if (nz_bits[i])  low_nz  = NW'(i);
    end
  end

  assign start_node = ($countones(odd_bits) == 2) ? low_odd : low_nz;

  always_comb begin
    sts.grew        = (reach_step != reach_r);
    sts.conn_ok     = ((nz_bits & ~reach_r) == '0);
    sts.no_nodes    = (nz_bits == '0);
    sts.odd_many    = ($countones(odd_bits) > 2);
    sts.overflow    = overflow_r;
    sts.t_end       = (t_r == total_r);
    sts.used_t      = used_r[t_r[IW-1:0]];
    sts.incident    = (rd_a == cur_r) || (rd_b == cur_r);
    sts.self_loop   = (rd_a == rd_b);
    sts.far_reached = far;
    sts.fb_valid    = fb_valid_r;
  end

  // Tile list: written at load, read at the scan index.
  always_ff @(posedge clk) begin
    if (store_ok) mem[total_r[IW-1:0]] <= {in_tile_end_a, in_tile_end_b};
    rd_r <= mem[t_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int u = 0; u < NODE_COUNT; u++) begin
        deg_r[u] <= '0;
        for (int v = 0; v < NODE_COUNT; v++) cnt_r[u][v] <= '0;
      end
      used_r     <= '0;
      total_r    <= '0;
      overflow_r <= 1'b0;
    end else begin
      if (cmd.load && tile_ok && !store_ok) overflow_r <= 1'b1;
      if (store_ok) total_r <= total_r + CW'(1);
      for (int u = 0; u < NODE_COUNT; u++) begin
        if (store_ok)
          deg_r[u] <= deg_r[u] + DW'(in_tile_end_a == NW'(u)) + DW'(in_tile_end_b == NW'(u));
        else if (cmd.take)
          deg_r[u] <= deg_r[u] - DW'(ta == NW'(u)) - DW'(tb == NW'(u));
        for (int v = 0; v < NODE_COUNT; v++) begin
          if (store_ok &&
              (((in_tile_end_a == NW'(u)) && (in_tile_end_b == NW'(v))) ||
               ((in_tile_end_a == NW'(v)) && (in_tile_end_b == NW'(u)))))
            cnt_r[u][v] <= cnt_r[u][v] + CW'(1);
          else if (cmd.take &&
                   (((ta == NW'(u)) && (tb == NW'(v))) ||
                    ((ta == NW'(v)) && (tb == NW'(u)))))
            cnt_r[u][v] <= cnt_r[u][v] - CW'(1);
        end
      end
      if (cmd.take) begin
        for (int i = 0; i < MAX_TILES; i++)
          if (take_idx == IW'(i)) used_r[i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reach_r    <= '0;
      ex_r       <= 1'b0;
      fb_valid_r <= 1'b0;
      t_r        <= '0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= cmd.take || cmd.emit_final || cmd.emit_fail;
      if (cmd.conn_init) begin
        ex_r <= 1'b0;
        for (int i = 0; i < NODE_COUNT; i++) reach_r[i] <= (low_nz == NW'(i));
      end else if (cmd.bridge_init) begin
        ex_r <= 1'b1;
        for (int i = 0; i < NODE_COUNT; i++) reach_r[i] <= (rd_a == NW'(i));
      end else if (cmd.bfs_step) begin
        reach_r <= reach_step;
      end
      if (cmd.scan_start) begin
        t_r        <= '0;
        fb_valid_r <= 1'b0;
      end else begin
        if (cmd.t_adv)  t_r        <= t_r + CW'(1);
        if (cmd.set_fb) fb_valid_r <= 1'b1;
      end
      if (cmd.set_fb) begin
        fb_t_r <= t_r[IW-1:0];
        fb_a_r <= rd_a;
        fb_b_r <= rd_b;
      end
      if (cmd.set_start) cur_r <= start_node;
      if (cmd.take) begin
        // Show the node held so far; advance to the far end of the tile.
        out_path_node   <= cur_r;
        out_status      <= efp_pkg::ST_PATH;
        out_last_result <= 1'b0;
        cur_r           <= (ta == cur_r) ? tb : ta;
      end else if (cmd.emit_final) begin
        out_path_node   <= cur_r;
        out_status      <= efp_pkg::ST_PATH;
        out_last_result <= 1'b1;
      end else if (cmd.emit_fail) begin
        out_path_node   <= '0;
        out_status      <= cmd.fail_code;
        out_last_result <= 1'b1;
      end
    end
  end

endmodule

[sv/euler_path_fleury_small_graph.sv]
// Top level: Euler path over domino tiles by Fleury's algorithm on a small multigraph.
// Load: a tile that is not the last is taken while busy stays low, so tiles may arrive back
//   to back. The last tile raises busy for the check and walk.
// Check: overflow and empty-graph tests, then reachability steps (at most NODE_COUNT) and the odd count.
// Walk: each tile index probed passes a read state (tile list read port) and a check state, plus up
//   to NODE_COUNT reachability steps per bridge test; each path node comes after a full rescan.
// Results appear one per strobe; the receiver cannot stall. Sync active-low reset clears
//   counts, degrees, tile marks and the controller; stores are also cleared after each run.
module euler_path_fleury_small_graph #(
  parameter int NODE_COUNT = efp_pkg::NODE_COUNT_DEF,
  parameter int MAX_TILES  = efp_pkg::MAX_TILES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [efp_pkg::NODE_W-1:0] in_tile_end_a,
  input  logic [efp_pkg::NODE_W-1:0] in_tile_end_b,
  input  logic                       in_last_tile,
  output logic                       out_valid,
  output logic [efp_pkg::NODE_W-1:0] out_path_node,
  output logic [1:0]                 out_status,
  output logic                       out_last_result
);

  efp_pkg::cmd_t cmd;
  efp_pkg::sts_t sts;

  // Controller: sequence load, connectivity, odd count and the bridge-aware walk.
  efp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_last_tile (in_last_tile),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy)
  );

  // Datapath: hold the graph, run reachability steps, drive the result item.
  efp_dp #(
    .NODE_COUNT (NODE_COUNT),
    .MAX_TILES  (MAX_TILES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tile_end_a   (in_tile_end_a),
    .in_tile_end_b   (in_tile_end_b),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_path_node   (out_path_node),
    .out_status      (out_status),
    .out_last_result (out_last_result)
  );

  // A failure item always ends the run.
  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != efp_pkg::ST_PATH) |-> out_last_result)
    else $error("failure item without last mark");

  // A failure item carries node zero.
  a_fail_node: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != efp_pkg::ST_PATH) |-> (out_path_node == '0))
    else $error("failure item with nonzero node");

  // The last tile starts the check.
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_tile |=> busy)
    else $error("last tile did not start the run");

  // Nothing follows the final item of a run at once.
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |=> !out_valid)
    else $error("item right after the final item");

  // The final item leaves the block idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |-> !busy)
    else $error("busy after the final item");

endmodule
